@@ design/drt_pkg.sv @@
// Shared types, constants and codes for the delimited row tokenizer.
package drt_pkg;

    localparam int unsigned FIELD_COUNT_W      = 9;
    localparam int unsigned CHAR_LIMIT_W       = 16;
    localparam int unsigned CFG_INDEX_W        = 3;
    localparam int unsigned CFG_DATA_W         = 16;
    localparam int unsigned MAX_FIELDS_DEFAULT = 256;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUOTE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMENT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NL_QUOTES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_LIMIT = 3'd4;

    // Error codes carried with a row end
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NO_DATA    = 2'd1;
    localparam logic [1:0] ERR_TOO_CHARS  = 2'd2;
    localparam logic [1:0] ERR_TOO_FIELDS = 2'd3;

    typedef enum logic [2:0] {
        MODE_ROW_START = 3'd0,
        MODE_SKIP      = 3'd1,
        MODE_UNQUOTED  = 3'd2,
        MODE_QUOTED    = 3'd3,
        MODE_PENDING   = 3'd4,
        MODE_SPACE     = 3'd5
    } parse_mode_t;

    typedef struct packed {
        logic [7:0]              separator;
        logic [7:0]              quote_byte;
        logic [7:0]              comment_byte;
        logic                    newline_in_quotes;
        logic [CHAR_LIMIT_W-1:0] char_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0]               out_byte;
        logic                     byte_valid;
        logic                     field_end;
        logic                     row_end;
        logic [FIELD_COUNT_W-1:0] field_count;
        logic [1:0]               error_code;
        logic                     last;
    } result_t;

    // Results produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

@@ design/drt_parse.sv @@
// Parser state and single-pass decode of one input byte into up to two results.
module drt_parse #(
    parameter int unsigned MAX_FIELDS = drt_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    in_byte,
    input  logic          end_of_file,
    input  drt_pkg::cfg_t cfg,
    output drt_pkg::push_t push
);
    import drt_pkg::*;

    localparam logic [FIELD_COUNT_W-1:0] MaxFields = FIELD_COUNT_W'(MAX_FIELDS);

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_STORE,
        ACT_FIELD,
        ACT_FIELD_ROW,
        ACT_ROW_ONLY,
        ACT_LIMIT
    } act_t;

    parse_mode_t              mode_reg, mode_next, mode_a, mode_row;
    logic [FIELD_COUNT_W-1:0] fields_reg, fields_next, fields_a;
    logic [CHAR_LIMIT_W-1:0]  bytes_reg, bytes_next, bytes_a;
    logic                     pre_store, front_eof, do_row;
    act_t                     act;
    logic [1:0]               limit_err;
    logic                     ws, is_nl, is_q, nl;
    result_t                  row_res, front_res;

    assign ws    = (cfg.separator == 8'd0);
    assign is_nl = (in_byte == CHAR_NEWLINE);
    assign is_q  = (in_byte == cfg.quote_byte);
    assign nl    = !end_of_file && is_nl;

    // Work done before the in-row handling: skipping, pending quote, row start.
    always_comb
    begin
        mode_a    = mode_reg;
        fields_a  = fields_reg;
        bytes_a   = bytes_reg;
        pre_store = 1'b0;
        front_eof = 1'b0;
        do_row    = 1'b0;
        case (mode_reg)
            MODE_SKIP:
            begin
                if (end_of_file)
                begin
                    front_eof = 1'b1;
                    mode_a    = MODE_ROW_START;
                end
                else if (is_nl)
                begin
                    mode_a = MODE_ROW_START;
                end
            end
            MODE_PENDING:
            begin
                if (!end_of_file && is_q)
                begin
                    pre_store = 1'b1;
                    mode_a    = MODE_QUOTED;
                end
                else if (ws && !end_of_file && in_byte != CHAR_SPACE && !is_nl)
                begin
                    pre_store = 1'b1;
                    mode_a    = MODE_QUOTED;
                    do_row    = 1'b1;
                end
                else
                begin
                    mode_a = MODE_UNQUOTED;
                    do_row = 1'b1;
                end
            end
            MODE_UNQUOTED, MODE_QUOTED, MODE_SPACE:
            begin
                do_row = 1'b1;
            end
            default:
            begin
                mode_a = MODE_ROW_START;
                if (end_of_file)
                begin
                    front_eof = 1'b1;
                end
                else if (in_byte == cfg.comment_byte)
                begin
                    mode_a = MODE_SKIP;
                end
                else
                begin
                    fields_a = '0;
                    bytes_a  = '0;
                    mode_a   = ws ? MODE_SPACE : MODE_UNQUOTED;
                    do_row   = 1'b1;
                end
            end
        endcase
        if (pre_store)
        begin
            bytes_a = bytes_a + CHAR_LIMIT_W'(1);
        end
    end

    // In-row decode: the action taken and the mode it leads to.
    always_comb
    begin
        act       = ACT_NONE;
        mode_row  = mode_a;
        limit_err = ERR_NONE;
        if (!do_row)
        begin
            act = ACT_NONE;
        end
        else if (bytes_a >= cfg.char_limit || fields_a >= MaxFields)
        begin
            act       = ACT_LIMIT;
            limit_err = (bytes_a >= cfg.char_limit) ? ERR_TOO_CHARS : ERR_TOO_FIELDS;
            mode_row  = (end_of_file || is_nl) ? MODE_ROW_START : MODE_SKIP;
        end
        else if (mode_a == MODE_QUOTED)
        begin
            if ((!end_of_file && !is_q && !nl) || (nl && cfg.newline_in_quotes))
            begin
                act = ACT_STORE;
            end
            else if (!end_of_file && is_q)
            begin
                mode_row = MODE_PENDING;
            end
            else
            begin
                act      = ACT_FIELD_ROW;
                mode_row = MODE_ROW_START;
            end
        end
        else if (mode_a == MODE_SPACE && ws)
        begin
            if (!end_of_file && is_q)
            begin
                mode_row = MODE_QUOTED;
            end
            else if (end_of_file || nl)
            begin
                act      = ACT_ROW_ONLY;
                mode_row = MODE_ROW_START;
            end
            else if (in_byte != CHAR_SPACE)
            begin
                act      = ACT_STORE;
                mode_row = MODE_UNQUOTED;
            end
        end
        else if (ws)
        begin
            if (end_of_file || nl)
            begin
                act      = ACT_FIELD_ROW;
                mode_row = MODE_ROW_START;
            end
            else if (in_byte == CHAR_SPACE)
            begin
                act      = ACT_FIELD;
                mode_row = MODE_SPACE;
            end
            else
            begin
                act = ACT_STORE;
            end
        end
        else
        begin
            mode_row = MODE_UNQUOTED;
            if (!end_of_file && is_q)
            begin
                mode_row = MODE_QUOTED;
            end
            else if (end_of_file || nl)
            begin
                act      = ACT_FIELD_ROW;
                mode_row = MODE_ROW_START;
            end
            else if (in_byte == cfg.comment_byte)
            begin
                act      = ACT_FIELD_ROW;
                mode_row = MODE_SKIP;
            end
            else if (in_byte == cfg.separator)
            begin
                act = ACT_FIELD;
            end
            else
            begin
                act = ACT_STORE;
            end
        end
    end

    // Next state
    always_comb
    begin
        mode_next   = mode_row;
        fields_next = fields_a;
        bytes_next  = bytes_a;
        case (act)
            ACT_STORE:
            begin
                bytes_next = bytes_a + CHAR_LIMIT_W'(1);
            end
            ACT_FIELD, ACT_FIELD_ROW:
            begin
                bytes_next  = bytes_a + CHAR_LIMIT_W'(1);
                fields_next = fields_a + FIELD_COUNT_W'(1);
            end
            default:
            begin
                bytes_next = bytes_a;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        row_res   = '0;
        front_res = '0;
        case (act)
            ACT_STORE:
            begin
                row_res.out_byte   = in_byte;
                row_res.byte_valid = 1'b1;
            end
            ACT_FIELD:
            begin
                row_res.field_end = 1'b1;
            end
            ACT_FIELD_ROW:
            begin
                row_res.field_end   = 1'b1;
                row_res.row_end     = 1'b1;
                row_res.field_count = fields_a + FIELD_COUNT_W'(1);
            end
            ACT_ROW_ONLY:
            begin
                row_res.row_end     = 1'b1;
                row_res.field_count = fields_a;
                row_res.error_code  = (fields_a == '0) ? ERR_NO_DATA : ERR_NONE;
            end
            ACT_LIMIT:
            begin
                row_res.row_end     = 1'b1;
                row_res.field_count = fields_a;
                row_res.error_code  = limit_err;
            end
            default:
            begin
                row_res = '0;
            end
        endcase

        if (front_eof)
        begin
            front_res.row_end    = 1'b1;
            front_res.error_code = ERR_NO_DATA;
        end
        else
        begin
            front_res.out_byte   = cfg.quote_byte;
            front_res.byte_valid = 1'b1;
        end

        push.second = row_res;
        if (front_eof || pre_store)
        begin
            push.first = front_res;
            push.count = (act != ACT_NONE) ? 2'd2 : 2'd1;
        end
        else
        begin
            push.first = row_res;
            push.count = (act != ACT_NONE) ? 2'd1 : 2'd0;
        end
        if (push.count == 2'd2)
        begin
            push.second.last = 1'b1;
        end
        else
        begin
            push.first.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ROW_START;
            fields_reg <= '0;
            bytes_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            fields_reg <= fields_next;
            bytes_reg  <= bytes_next;
        end
    end

endmodule

@@ design/drt_outq.sv @@
// Four-entry result queue that takes up to two results a cycle and gives one while out_ready is high.
module drt_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  drt_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output drt_pkg::result_t out_res
);
    import drt_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    logic       pop;

    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = push_en ? push.count : 2'd0;

    assign wr_ptr_next = wr_ptr_reg + n_push;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, n_push} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/delimited_row_tokenizer.sv @@
// Top level of the delimited row tokenizer: configuration registers, parser and result queue.
//
// The tokenizer takes one character, or an end-of-file mark, in each input transfer and
// splits the text into rows and fields. Every result transfer carries either one field
// byte, a field-end mark, a row-end mark with the row's field count and an error code, or a
// field end and row end together; tlast is set on the final result that an input character
// causes, and a character may cause none, one or two. Input characters are decoded in one
// pass of combinational logic as they are taken, so the block accepts one character per
// clock cycle while the queue has room. Results leave through a four-entry queue at one per
// cycle while m_axis_tready is high; the input is ready whenever the queue has room for two
// results, so an output stall holds the input only once more than two results wait, and
// a long run of characters that each cause two results is slowed by the single output port.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and must only
// be changed while no results are outstanding. A separator of zero selects whitespace mode.
module delimited_row_tokenizer #(
    parameter int unsigned MAX_FIELDS = drt_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] in_byte
    input  logic                               s_axis_tuser,   // [0] end_of_file
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [23:0]                        m_axis_tdata,   // [7:0] out_byte,
                                                               // [16:8] field_count,
                                                               // [18:17] error_code,
                                                               // [23:19] zero
    output logic [2:0]                         m_axis_tuser,   // [0] byte_valid,
                                                               // [1] field_end, [2] row_end
    output logic                               m_axis_tlast,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [drt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [drt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import drt_pkg::*;

    cfg_t    cfg_reg;
    logic    in_fire;
    logic    room;
    push_t   push;
    result_t out_res;

    // Configuration registers; writes to an index beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator         <= 8'd44;
            cfg_reg.quote_byte        <= 8'd34;
            cfg_reg.comment_byte      <= 8'd35;
            cfg_reg.newline_in_quotes <= 1'b0;
            cfg_reg.char_limit        <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEPARATOR:  cfg_reg.separator         <= cfg_data[7:0];
                REG_QUOTE:      cfg_reg.quote_byte        <= cfg_data[7:0];
                REG_COMMENT:    cfg_reg.comment_byte      <= cfg_data[7:0];
                REG_NL_QUOTES:  cfg_reg.newline_in_quotes <= cfg_data[0];
                REG_CHAR_LIMIT: cfg_reg.char_limit        <= cfg_data[CHAR_LIMIT_W-1:0];
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // A character is taken whenever the queue can absorb the two results it may cause.
    assign s_axis_tready = room;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    drt_parse #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (in_fire),
        .in_byte     (s_axis_tdata),
        .end_of_file (s_axis_tuser),
        .cfg         (cfg_reg),
        .push        (push)
    );

    drt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (in_fire),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result onto the stream fields.
    assign m_axis_tdata = {5'd0, out_res.error_code, out_res.field_count, out_res.out_byte};
    assign m_axis_tuser = {out_res.row_end, out_res.field_end, out_res.byte_valid};
    assign m_axis_tlast = out_res.last;

endmodule
